// ===== rtl/mavg_pkg.sv =====
// Shared constants, register codes and types for the moving-average filter.
package mavg_pkg;

  localparam int WIN_DEPTH = 20;
  localparam int SMP_W     = 12;
  localparam int FRAC_W    = 4;
  localparam int VAL_W     = SMP_W + FRAC_W;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int POS_W     = $clog2(WIN_DEPTH);
  localparam int SUM_W     = SMP_W + $clog2(WIN_DEPTH);
  localparam int DIV_W     = SUM_W + FRAC_W;
  localparam int DIV_STEPS = (DIV_W + 1) / 2;
  localparam int NUM_W     = 2 * DIV_STEPS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_W-1:0] REJECT_LOW_RST  = CFG_W'(50);
  localparam logic [CFG_W-1:0] REJECT_HIGH_RST = CFG_W'(3200);
  localparam logic [CFG_W-1:0] STAB_THR_RST    = CFG_W'(120);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REJECT_LOW  = 2'd0,
    REG_REJECT_HIGH = 2'd1,
    REG_STAB_THRESH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/mavg_cell.sv =====
// One window cell: holds a stored sample and takes its neighbor's value on a shift.
module mavg_cell import mavg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [SMP_W-1:0] d,
  output logic [SMP_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/mavg_div.sv =====
// Restoring divider that retires two quotient bits per cycle for the window mean.
module mavg_div import mavg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [VAL_W-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] step_cnt;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  div_d;
  logic [CNT_W:0]    r1;
  logic [CNT_W:0]    r2;
  logic [CNT_W-1:0]  rem_a;
  logic [CNT_W-1:0]  rem_b;
  logic              q_a;
  logic              q_b;

  always_comb begin
    r1    = {rem, num[NUM_W-1]};
    q_a   = r1 >= {1'b0, div_d};
    rem_a = q_a ? CNT_W'(r1 - {1'b0, div_d}) : r1[CNT_W-1:0];
    r2    = {rem_a, num[NUM_W-2]};
    q_b   = r2 >= {1'b0, div_d};
    rem_b = q_b ? CNT_W'(r2 - {1'b0, div_d}) : r2[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step_cnt == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      step_cnt <= STEP_W'(DIV_STEPS);
      num      <= NUM_W'(req.dividend);
      rem      <= '0;
      quo      <= '0;
      div_d    <= req.divisor;
    end else if (busy) begin
      step_cnt <= step_cnt - STEP_W'(1);
      num      <= {num[NUM_W-3:0], 2'b00};
      rem      <= rem_b;
      quo      <= {quo[NUM_W-3:0], q_a, q_b};
    end
  end

  assign quotient = quo[VAL_W-1:0];

endmodule

// ===== rtl/moving_average_with_reject_and_stability.sv =====
// Top level of the moving-average filter with sample rejection and a stability flag.
//
//   Channel   Signals                                          Direction
//   input     in_valid, in_ready, sample_mv                    request in
//   output    out_valid, out_ready, filtered_value,            result out
//             sample_rejected, window_stable
//   config    cfg_we, cfg_index, cfg_data                      register write
//
// A stored sample makes one lap of the cell ring, which feeds the sum, minimum and maximum;
// then the divider runs. A rejected sample skips the scan and the divider, since the
// window does not change.
// One request is worked on at a time; the next is taken while a result still waits.
// Reset clears the window, the fill count and the registers to their defaults.
// A stalled output holds its result, and a finished request waits until it is taken.
module moving_average_with_reject_and_stability import mavg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SMP_W-1:0]     sample_mv,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VAL_W-1:0]     filtered_value,
  output logic                 sample_rejected,
  output logic                 window_stable,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  reject_low;
  logic [CFG_W-1:0]  reject_high;
  logic [CFG_W-1:0]  stab_thr;
  logic [CNT_W-1:0]  fill;
  logic [SMP_W-1:0]  spread;
  logic [POS_W-1:0]  scan_cnt;
  logic [SUM_W-1:0]  sum;
  logic [SMP_W-1:0]  win_min;
  logic [SMP_W-1:0]  win_max;
  logic [VAL_W-1:0]  res_value;
  logic              res_rej;

  logic [SMP_W-1:0]  chain [WIN_DEPTH];
  logic [SMP_W-1:0]  tail;
  logic [SMP_W-1:0]  head_in;
  logic              shift;
  logic              accept;
  logic              reject_now;
  logic              full;
  logic              scan_last;
  logic              out_free;
  logic [SUM_W-1:0]  sum_next;
  logic [SMP_W-1:0]  min_next;
  logic [SMP_W-1:0]  max_next;
  div_req_t          div_req;
  logic              div_done;
  logic [VAL_W-1:0]  div_quo;

  always_comb begin
    in_ready   = state == ST_IDLE;
    accept     = in_valid && in_ready;
    tail       = chain[WIN_DEPTH-1];
    reject_now = sample_mv < reject_low || sample_mv > reject_high;
    full       = fill == CNT_W'(WIN_DEPTH);
    shift      = (accept && !reject_now) || state == ST_SCAN;
    head_in    = (state == ST_SCAN) ? tail : sample_mv;
    scan_last  = scan_cnt == POS_W'(WIN_DEPTH - 1);
    out_free   = !out_valid || out_ready;
    sum_next   = sum + SUM_W'(tail);
    min_next   = (tail < win_min) ? tail : win_min;
    max_next   = (tail > win_max) ? tail : win_max;
    div_req.start    = state == ST_SCAN && scan_last;
    div_req.dividend = {sum_next, {FRAC_W{1'b0}}};
    div_req.divisor  = fill;
  end

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      mavg_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (head_in),
        .q     (chain[i])
      );
    end else begin : g_body
      mavg_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (chain[i-1]),
        .q     (chain[i])
      );
    end
  end

  mavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      spread      <= '0;
      out_valid   <= 1'b0;
      reject_low  <= REJECT_LOW_RST;
      reject_high <= REJECT_HIGH_RST;
      stab_thr    <= STAB_THR_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_REJECT_LOW:  reject_low  <= cfg_data;
          REG_REJECT_HIGH: reject_high <= cfg_data;
          REG_STAB_THRESH: stab_thr    <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (reject_now) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
              if (!full) begin
                fill <= fill + CNT_W'(1);
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            spread <= max_next - min_next;
            state  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      scan_cnt <= '0;
      sum      <= '0;
      win_min  <= '1;
      win_max  <= '0;
      res_rej  <= reject_now;
      if (reject_now) begin
        res_value <= full ? {chain[0], {FRAC_W{1'b0}}} : {sample_mv, {FRAC_W{1'b0}}};
      end
    end else if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + POS_W'(1);
      sum      <= sum_next;
      win_min  <= min_next;
      win_max  <= max_next;
    end else if (state == ST_DIV && div_done) begin
      res_value <= div_quo;
    end
    if (state == ST_DONE && out_free) begin
      filtered_value  <= res_value;
      sample_rejected <= res_rej;
      window_stable   <= spread < stab_thr;
    end
  end

endmodule

// ===== rtl/mavg_checker.sv =====
// Port-level checks for the moving-average filter, bound to its top level.
module mavg_port_checker import mavg_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [SMP_W-1:0]     sample_mv,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [VAL_W-1:0]     filtered_value,
  input logic                 sample_rejected,
  input logic                 window_stable,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data
);

  // After reset the block is empty and ready for a request.
  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // Only one request is in flight at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // A passed-through value is a whole number of millivolts.
  a_reject_whole_mv: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_rejected |-> filtered_value[FRAC_W-1:0] == '0)
    else $error("rejected result carries a fraction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_value)
      && $stable(sample_rejected) && $stable(window_stable))
    else $error("stalled result changed");

endmodule

bind moving_average_with_reject_and_stability mavg_port_checker u_mavg_checker (.*);
